// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file ocmp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held low.
`define AST_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define AST_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/ocmp_pkg.sv
package ocmp_pkg;

  localparam int NUM_STAGES = 5;
  localparam int LANES      = 4;

  // lane order inside the blend datapath
  localparam int LANE_R = 0;
  localparam int LANE_G = 1;
  localparam int LANE_B = 2;
  localparam int LANE_A = 3;

  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [15:0] FULL_SQ    = 16'd65025;
  // floor(x/3) == (x*683)>>11 for every x up to 765
  localparam logic [9:0]  RECIP3     = 10'd683;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t game;
    rgba_t box;
  } pair_t;

  // alpha terms after stage 1
  typedef struct packed {
    logic [7:0] sa;
    logic [7:0] sa_inv;
    logic [7:0] da;
    logic [7:0] da_inv;
    rgba_t      game;
    rgba_t      box;
  } prep_t;

  // per-lane operands after stage 2: out = (lin + da*inner/255)/255
  typedef struct packed {
    logic [15:0] inner;
    logic [15:0] lin;
    logic [7:0]  da;
  } lane_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } ctrl_t;

  // floor(x/255) for x up to 255*65025: reciprocal estimate, then one correction
  function automatic logic [15:0] div255(input logic [23:0] x);
    logic [31:0] t;
    logic [15:0] q0;
    logic [24:0] r;
    t  = {8'd0, x} + {x, 8'd0};
    q0 = t[31:16];
    r  = {1'b0, x} - ({1'b0, q0, 8'd0} - {9'd0, q0});
    return (r >= 25'd255) ? q0 + 16'd1 : q0;
  endfunction

endpackage

// File: rtl/core/ocmp_ctrl.sv
module ocmp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            out_tready,
  output ocmp_pkg::ctrl_t ctrl,
  output logic            out_tvalid
);
  import ocmp_pkg::*;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES-1:0] adv;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
    v_nxt[0] = adv[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      v_nxt[i] = adv[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctrl.load = adv;
  assign out_tvalid = v_r[NUM_STAGES-1];

endmodule

// File: rtl/core/ocmp_prep.sv
module ocmp_prep (
  input  logic            clk,
  input  logic            load,
  input  ocmp_pkg::pair_t pix,
  output ocmp_pkg::prep_t prep_r
);
  import ocmp_pkg::*;

  prep_t       prep_nxt;
  logic [9:0]  sum;
  logic [19:0] avg_prod;
  logic [7:0]  avg;
  logic [7:0]  ga_inv;

  always_comb begin
    sum      = {2'd0, pix.game.red} + {2'd0, pix.game.green} + {2'd0, pix.game.blue};
    avg_prod = {10'd0, sum} * {10'd0, RECIP3};
    avg      = avg_prod[18:11];
    ga_inv   = FULL_SCALE - pix.game.alpha;

    prep_nxt.sa     = (pix.box.alpha != FULL_SCALE) ? {1'b0, pix.box.alpha[7:1]}
                                                    : pix.box.alpha;
    prep_nxt.sa_inv = FULL_SCALE - prep_nxt.sa;
    prep_nxt.da     = (avg > ga_inv) ? avg : ga_inv;
    prep_nxt.da_inv = FULL_SCALE - prep_nxt.da;
    prep_nxt.game   = pix.game;
    prep_nxt.box    = pix.box;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

// File: rtl/core/ocmp_prod.sv
module ocmp_prod (
  input  logic                                      clk,
  input  logic                                      load,
  input  ocmp_pkg::prep_t                           prep,
  output ocmp_pkg::lane_t [ocmp_pkg::LANES-1:0]     lanes_r
);
  import ocmp_pkg::*;

  lane_t [LANES-1:0] lanes_nxt;

  function automatic lane_t colour_terms(input logic [7:0] s, input logic [7:0] g,
                                         input prep_t p);
    lane_t       l;
    logic [15:0] ps;
    logic [15:0] pg;
    logic [16:0] acc;
    ps      = {8'd0, s} * {8'd0, p.sa};
    pg      = {8'd0, g} * {8'd0, p.sa_inv};
    acc     = {1'b0, ps} + {1'b0, pg};
    l.inner = acc[15:0];          // never above 255*255
    l.lin   = {8'd0, p.da_inv} * {8'd0, s};
    l.da    = p.da;
    return l;
  endfunction

  always_comb begin
    lanes_nxt[LANE_R] = colour_terms(prep.box.red,   prep.game.red,   prep);
    lanes_nxt[LANE_G] = colour_terms(prep.box.green, prep.game.green, prep);
    lanes_nxt[LANE_B] = colour_terms(prep.box.blue,  prep.game.blue,  prep);
    lanes_nxt[LANE_A].inner = FULL_SQ - ({8'd0, prep.da_inv} * {8'd0, prep.sa_inv});
    lanes_nxt[LANE_A].lin   = {8'd0, prep.da_inv} * {8'd0, prep.sa};
    lanes_nxt[LANE_A].da    = prep.da;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

// File: rtl/core/ocmp_lane.sv
module ocmp_lane (
  input  logic            clk,
  input  logic [2:0]      load,
  input  ocmp_pkg::lane_t lane,
  output logic [7:0]      res_r
);
  import ocmp_pkg::*;

  logic [23:0] p_r;
  logic [15:0] lin_r;
  logic [16:0] sum_r;
  logic [16:0] sum_nxt;
  logic [15:0] q_nxt;

  assign sum_nxt = {1'b0, div255(p_r)} + {1'b0, lin_r};
  assign q_nxt   = div255({7'd0, sum_r});

  always_ff @(posedge clk) begin
    if (load[0]) begin
      p_r   <= {16'd0, lane.da} * {8'd0, lane.inner};
      lin_r <= lane.lin;
    end
    if (load[1]) begin
      sum_r <= sum_nxt;
    end
    if (load[2]) begin
      res_r <= q_nxt[7:0];        // result is at most 255
    end
  end

endmodule

// File: rtl/core/overlay_pixel_compositor_unit.sv
// Overlay pixel compositor: one background and one overlay RGBA8 pixel in, one blended pixel out.
// Throughput: one word per cycle while the output is not stalled,
// set by a five-stage pipeline with a register after each multiply.
// Stalls back up stage by stage; empty stages fill while the output word waits.
// Reset: synchronous, active low; clears the stage valid bits only, data registers are not reset.
module overlay_pixel_compositor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] game_red, [15:8] game_green, [23:16] game_blue, [31:24] game_alpha,
  // [39:32] box_red, [47:40] box_green, [55:48] box_blue, [63:56] box_alpha
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
  output logic [31:0] out_tdata
);
  import ocmp_pkg::*;

  ctrl_t             ctrl;
  pair_t             pix;
  prep_t             prep;
  lane_t [LANES-1:0] lanes;
  logic  [7:0]       res [LANES];

  // unpack the input word
  assign pix.game.red   = in_tdata[7:0];
  assign pix.game.green = in_tdata[15:8];
  assign pix.game.blue  = in_tdata[23:16];
  assign pix.game.alpha = in_tdata[31:24];
  assign pix.box.red    = in_tdata[39:32];
  assign pix.box.green  = in_tdata[47:40];
  assign pix.box.blue   = in_tdata[55:48];
  assign pix.box.alpha  = in_tdata[63:56];

  // valid bits and per-stage load enables
  ocmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl),
    .out_tvalid (out_tvalid)
  );

  assign in_tready = ctrl.load[0];

  // stage 1: overlay alpha halving, background alpha inversion and channel mean
  ocmp_prep u_prep (
    .clk    (clk),
    .load   (ctrl.load[0]),
    .pix    (pix),
    .prep_r (prep)
  );

  // stage 2: 8x8 products per lane
  ocmp_prod u_prod (
    .clk     (clk),
    .load    (ctrl.load[1]),
    .prep    (prep),
    .lanes_r (lanes)
  );

  // stages 3..5: da*inner, first /255 and add, second /255 into the output register
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ocmp_lane u_lane (
      .clk   (clk),
      .load  (ctrl.load[NUM_STAGES-1:2]),
      .lane  (lanes[i]),
      .res_r (res[i])
    );
  end

  assign out_tdata = {res[LANE_A], res[LANE_B], res[LANE_G], res[LANE_R]};

endmodule

// File: rtl/core/ocmp_checker.sv
`include "assert_macros.svh"

module ocmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled output word stays put
  `AST_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "output word dropped or changed while stalled")

  // reset empties the pipeline
  `AST_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // a taken output frees every stage, so the input side must be open
  `AST_CLK(a_ready_chain, clk, rst_n, out_tready |-> in_tready, "input blocked while output drains")

  // an opaque overlay, run through an unstalled pipe, gives an opaque result
  `AST_CLK(a_opaque, clk, rst_n, $past(in_tvalid && in_tready && in_tdata[63:56] == 8'hFF && rst_n, 5) && $past(out_tready && rst_n, 4) && $past(out_tready && rst_n, 3) && $past(out_tready && rst_n, 2) && $past(out_tready && rst_n, 1) |-> out_tvalid && out_tdata[31:24] == 8'hFF, "opaque overlay did not give full alpha")

endmodule

bind overlay_pixel_compositor_unit ocmp_checker u_ocmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sv/tb_overlay_pixel_compositor_unit.sv
module tb_overlay_pixel_compositor_unit;

  // blend arithmetic constants
  localparam int unsigned FULL    = 255;
  localparam int unsigned FULL_SQ = 255 * 255;

  localparam int N_RANDOM        = 1700;
  localparam int DRAIN_CYCLES    = 20;   // pipeline is 5 deep, leave margin for a stray word
  localparam int HOLD_OFF_AT     = 400;  // results taken before the long sink stall
  localparam int HOLD_OFF_CYCLES = 300;

  // per-side idling style, redrawn every 64 words
  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

  // directed stimulus: pixel pair, plus a hand-typed result where it is obvious
  typedef struct packed {
    logic [63:0] pair;
    logic        known;
    logic [31:0] want;
  } dir_row_t;

  localparam int N_DIR = 18;
  // pair bytes from the top: box a,b,g,r | game a,b,g,r
  // want bytes from the top: a,b,g,r
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{64'h0000_0000_0000_0000, 1'b1, 32'hFF00_0000}, // all clear: background fully see-through
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, // all ones
    '{64'h0000_0000_FF00_0000, 1'b1, 32'h0000_0000}, // opaque black bg, clear box
    '{64'hFFFF_FFFF_FF00_0000, 1'b1, 32'hFFFF_FFFF}, // opaque black bg, opaque white box
    '{64'hFE40_80C0_8010_2030, 1'b0, 32'h0},         // box alpha 254 halves to 127
    '{64'h01FF_00FF_4080_8080, 1'b0, 32'h0},         // box alpha 1 halves to 0
    '{64'h00FF_FFFF_00FF_0000, 1'b0, 32'h0},         // box alpha 0
    '{64'h7F12_3456_9ABC_DEF0, 1'b0, 32'h0},         // odd box alpha, truncation
    '{64'h8011_2233_C8C8_C8C8, 1'b0, 32'h0},         // gray mean above inverted alpha
    '{64'hC0AA_55AA_A55A_5A5A, 1'b0, 32'h0},         // mean equals inverted alpha
    '{64'hC0AA_55AA_A55A_5A59, 1'b0, 32'h0},         // mean one below inverted alpha
    '{64'hFF01_0203_FFFE_FFFF, 1'b0, 32'h0},         // mean of 764 truncates to 254
    '{64'h5555_5555_5555_5555, 1'b0, 32'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0},
    '{64'h80FF_0000_0000_0080, 1'b0, 32'h0},         // lone high bits
    '{64'hFF80_8080_00FF_00FF, 1'b0, 32'h0},         // opaque box, clear bg
    '{64'hFF20_4060_7F90_A0B0, 1'b0, 32'h0},         // opaque box over translucent bg
    '{64'h00FF_FFFF_FF33_6699, 1'b0, 32'h0}          // clear box over opaque colour
  };

  localparam string CH_NAME [4] = '{"red", "green", "blue", "alpha"};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  logic [31:0] pending_blends [$];  // blended pixels still owed by the block
  int          errors   = 0;
  logic        hold_off = 1'b0;     // set while the sink holds off; source then sends back to back

  always #5 clk = ~clk;

  overlay_pixel_compositor_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // "over" blend of the box pixel onto the game pixel; returns {a,b,g,r}
  function automatic logic [31:0] blend_over(input logic [63:0] pair);
    int unsigned game [4];
    int unsigned box [4];
    int unsigned sa, sa_inv, da, da_inv, avg, inner;
    logic [31:0] word;
    for (int k = 0; k < 4; k++) begin
      game[k] = 32'(pair[8*k +: 8]);
      box[k]  = 32'(pair[32 + 8*k +: 8]);
    end
    // overlay alpha halved unless fully opaque
    sa     = (box[3] != FULL) ? (box[3] >> 1) : box[3];
    sa_inv = FULL - sa;
    // stored bg alpha is inverted; a brighter gray mean wins over it
    da  = FULL - game[3];
    avg = (game[0] + game[1] + game[2]) / 3;
    if (avg > da) da = avg;
    da_inv = FULL - da;
    for (int k = 0; k < 3; k++) begin
      inner = box[k] * sa + game[k] * sa_inv;
      word[8*k +: 8] = 8'((da_inv * box[k] + (da * inner) / FULL) / FULL);
    end
    word[31:24] = 8'((da_inv * sa + (da * (FULL_SQ - da_inv * sa_inv)) / FULL) / FULL);
    return word;
  endfunction

  function automatic int draw_gap(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 13);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
    endcase
  endfunction

  // random pixel pair, skewed toward the alpha corner cases
  function automatic logic [63:0] random_pair();
    logic [7:0] gr, gg, gb, ga, br, bg, bb, ba;
    gr = 8'($urandom);
    gg = 8'($urandom);
    gb = 8'($urandom);
    ga = 8'($urandom);
    br = 8'($urandom);
    bg = 8'($urandom);
    bb = 8'($urandom);
    ba = 8'($urandom);
    case ($urandom_range(0, 5))
      0: ba = 8'hFF;                               // opaque box, alpha not halved
      1: ba = $urandom_range(0, 1) ? 8'hFE : 8'h00;
      2: begin                                     // gray bg, mean near inverted alpha
        gg = gr;
        gb = gr;
        ga = ~gr + 8'($urandom_range(0, 2)) - 8'd1;
      end
      3: ga = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      default: ;
    endcase
    return {ba, bb, bg, br, ga, gb, gg, gr};
  endfunction

  // source: directed table, then random words; gaps per word
  initial begin
    logic [63:0] word;
    int          gap;
    idle_mode_t  tx_mode;
    tx_mode = IDLE_NONE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIR + N_RANDOM; i++) begin
      if (i % 64 == 0) tx_mode = idle_mode_t'($urandom_range(0, 2));
      gap = hold_off ? 0 : draw_gap(tx_mode);
      // valid only drops when time will pass before the next word
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      word = (i < N_DIR) ? DIR_ROWS[i].pair : random_pair();
      in_tvalid <= 1'b1;
      in_tdata  <= word;
      do @(posedge clk); while (!in_tready);
      if (i < N_DIR && DIR_ROWS[i].known) pending_blends = {pending_blends, DIR_ROWS[i].want};
      else pending_blends = {pending_blends, blend_over(word)};
    end
    in_tvalid <= 1'b0;

    // drain, then linger in case the block emits an extra word
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_blends.size() == 0) begin
      $display("PASS overlay_pixel_compositor_unit");
    end else begin
      $display("FAIL overlay_pixel_compositor_unit");
    end
    $finish;
  end

  // sink: random stalls, one long hold-off to fill the pipe and back up the source
  initial begin
    int         stall;
    int         taken;
    idle_mode_t rx_mode;
    taken   = 0;
    rx_mode = IDLE_NONE;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) rx_mode = idle_mode_t'($urandom_range(0, 2));
      if (taken == HOLD_OFF_AT) begin
        hold_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        stall = draw_gap(rx_mode);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // result check: every accepted word against the oldest pending blend
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blends.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_blends.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (want[8*k +: 8] !== out_tdata[8*k +: 8]) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, CH_NAME[k],
                     want[8*k +: 8], out_tdata[8*k +: 8]);
            errors++;
          end
        end
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL overlay_pixel_compositor_unit");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ocmp_pkg.sv
rtl/core/ocmp_ctrl.sv
rtl/core/ocmp_prep.sv
rtl/core/ocmp_prod.sv
rtl/core/ocmp_lane.sv
rtl/core/overlay_pixel_compositor_unit.sv
rtl/core/ocmp_checker.sv
tb/sv/tb_overlay_pixel_compositor_unit.sv
